// ===== src/stt_pkg.sv =====
// Shared types, codes and sizes for the software timer table.
package stt_pkg;

   localparam int MAX_TIMERS = 8;
   localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
   localparam int DIV_W      = 16;
   localparam int ID_W       = 8;

   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_STOP   = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BELOW_RES = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic CFG_RESOLUTION = 1'b0;
   localparam logic CFG_TICKS      = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]  consumer;
      logic [DIV_W-1:0] period;
      logic [DIV_W-1:0] remaining;
      logic             periodic;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic             rem_only;
      logic [IDX_W-1:0] idx;
      entry_type        data;
   } entry_wr_type;

endpackage

// ===== src/software_timer_table.sv =====
// Top level of the software timer table: sequencer, prescaler and result output.
// A start item runs a serial divide of its delay by the resolution and then appends
// an entry if the quotient is nonzero and the table has room. A stop item scans the table
// one entry per cycle and, on a match, moves the last entry into the freed slot.
// A hardware tick that completes a system tick walks the table one entry per cycle, with
// a pause at each one-shot removal while the last entry moves into the freed slot.
// Every item then passes its results one at a time through the output register.
// Results of a tick are buffered and sent after the walk, so running reflects the table
// after the whole item. The input is not ready while an item is being processed.
module software_timer_table
   import stt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // consumer_id, delay_us, periodic
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status, fired_consumer, running
   output logic        rsp_tuser,   // fired
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_START_END,
      ST_STOP_SCAN,
      ST_TICK_SCAN,
      ST_DROP,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [15:0]       resolution_ff;
   logic [7:0]        ticks_ff;
   logic [7:0]        prescale_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  fire_cnt_ff;
   logic [CNT_W-1:0]  emit_ff;
   logic [1:0]        func_ff;
   logic [ID_W-1:0]   who_ff;
   logic              per_ff;
   logic [1:0]        status_ff;
   logic [ID_W-1:0]   fire_buf_ff [MAX_TIMERS];
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_fired_ff;
   logic [ID_W-1:0]   rsp_who_ff;
   logic              rsp_running_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              div_start;
   logic              div_done;
   logic [DIV_W-1:0]  quotient;
   logic [DIV_W-1:0]  divisor;
   logic [7:0]        tick_lim;
   logic [8:0]        pc_next;
   logic [CNT_W-1:0]  tail;
   logic [IDX_W-1:0]  rd_idx;
   entry_type         rd_entry;
   entry_wr_type      wr;
   logic [DIV_W-1:0]  rem_dec;
   logic              in_range;
   logic              emit_load;
   logic              emit_last;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign divisor    = (resolution_ff == '0) ? DIV_W'(1) : resolution_ff;
   assign tick_lim   = (ticks_ff == '0) ? 8'd1 : ticks_ff;
   assign pc_next    = {1'b0, prescale_ff} + 9'd1;
   assign div_start  = accept && (req_tuser == FUNC_START);
   assign tail       = count_ff - 1'b1;
   assign in_range   = idx_ff < count_ff;
   assign rem_dec    = (rd_entry.remaining != '0) ? rd_entry.remaining - 1'b1 : '0;
   assign emit_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign emit_last  = (fire_cnt_ff == '0) || (emit_ff == fire_cnt_ff - 1'b1);

   stt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[23:8]),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   stt_timer_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry)
   );

   always_comb begin
      rd_idx   = (state_ff == ST_DROP) ? tail[IDX_W-1:0] : idx_ff[IDX_W-1:0];
      wr       = '0;
      wr.idx   = idx_ff[IDX_W-1:0];
      case (state_ff)
         ST_START_END: begin
            wr.en                = (quotient != '0) && (count_ff < CNT_W'(MAX_TIMERS));
            wr.idx               = count_ff[IDX_W-1:0];
            wr.data.consumer     = who_ff;
            wr.data.period       = quotient;
            wr.data.remaining    = quotient;
            wr.data.periodic     = per_ff;
         end
         ST_TICK_SCAN: begin
            wr.en             = in_range && !(rem_dec == '0 && !rd_entry.periodic);
            wr.rem_only       = 1'b1;
            wr.data.remaining = (rem_dec == '0) ? rd_entry.period : rem_dec;
         end
         ST_DROP: begin
            wr.en   = 1'b1;
            wr.data = rd_entry;
         end
         default: begin
            wr.en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         resolution_ff <= 16'd1;
         ticks_ff      <= 8'd1;
         prescale_ff   <= '0;
         count_ff      <= '0;
         fire_cnt_ff   <= '0;
         emit_ff       <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CFG_RESOLUTION) begin
               resolution_ff <= csr_wdata;
            end else begin
               ticks_ff <= csr_wdata[7:0];
            end
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  func_ff     <= req_tuser;
                  who_ff      <= req_tdata[7:0];
                  per_ff      <= req_tdata[24];
                  status_ff   <= STATUS_OK;
                  fire_cnt_ff <= '0;
                  emit_ff     <= '0;
                  idx_ff      <= '0;
                  case (req_tuser)
                     FUNC_START: state_ff <= ST_DIVIDE;
                     FUNC_STOP:  state_ff <= ST_STOP_SCAN;
                     FUNC_TICK: begin
                        if (pc_next >= {1'b0, tick_lim}) begin
                           prescale_ff <= '0;
                           state_ff    <= ST_TICK_SCAN;
                        end else begin
                           prescale_ff <= pc_next[7:0];
                           state_ff    <= ST_EMIT;
                        end
                     end
                     default: state_ff <= ST_EMIT;
                  endcase
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  state_ff <= ST_START_END;
               end
            end
            ST_START_END: begin
               if (quotient == '0) begin
                  status_ff <= STATUS_BELOW_RES;
               end else if (count_ff >= CNT_W'(MAX_TIMERS)) begin
                  status_ff <= STATUS_FULL;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= ST_EMIT;
            end
            ST_STOP_SCAN: begin
               if (!in_range) begin
                  status_ff <= STATUS_NOT_FOUND;
                  state_ff  <= ST_EMIT;
               end else if (rd_entry.consumer == who_ff) begin
                  state_ff <= ST_DROP;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_TICK_SCAN: begin
               if (!in_range) begin
                  state_ff <= ST_EMIT;
               end else if (rem_dec == '0) begin
                  fire_buf_ff[fire_cnt_ff[IDX_W-1:0]] <= rd_entry.consumer;
                  fire_cnt_ff <= fire_cnt_ff + 1'b1;
                  if (rd_entry.periodic) begin
                     idx_ff <= idx_ff + 1'b1;
                  end else begin
                     state_ff <= ST_DROP;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_DROP: begin
               count_ff <= tail;
               state_ff <= (func_ff == FUNC_TICK) ? ST_TICK_SCAN : ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_load) begin
                  rsp_status_ff  <= status_ff;
                  rsp_fired_ff   <= (fire_cnt_ff != '0);
                  rsp_who_ff     <= (fire_cnt_ff != '0) ?
                                    fire_buf_ff[emit_ff[IDX_W-1:0]] : '0;
                  rsp_running_ff <= (count_ff != '0);
                  rsp_last_ff    <= emit_last;
                  emit_ff        <= emit_ff + 1'b1;
                  if (emit_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_running_ff, rsp_who_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TIMERS))
      else $error("Entry count exceeds the table size.");

   a_fire_bound: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= count_ff + (emit_ff - emit_ff) + fire_cnt_ff - fire_cnt_ff
                     + CNT_W'(MAX_TIMERS) - count_ff)
      else $error("More expiries recorded than the table can hold.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + 1'b1 ||
                         count_ff == $past(count_ff) - 1'b1))
      else $error("Entry count moved by more than one in a cycle.");

   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fired_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("An expiry result carries a non-ok status.");

   a_drop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DROP) |-> (count_ff != '0))
      else $error("Removal attempted on an empty table.");

endmodule

// ===== src/stt_divider.sv =====
// Serial restoring divider that produces one quotient bit per cycle.
module stt_divider
   import stt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIV_W);

   logic               busy_ff;
   logic               done_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [DIV_W:0]     rem_ff;
   logic [DIV_W-1:0]   quo_ff;
   logic [DIV_W-1:0]   dsr_ff;
   logic [DIV_W:0]     rem_sh;
   logic [DIV_W:0]     diff;
   logic               take;

   assign rem_sh = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};
   assign take   = rem_sh >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
            step_ff <= STEP_W'(DIV_W - 1);
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= take ? diff : rem_sh;
            quo_ff <= {quo_ff[DIV_W-2:0], take};
            step_ff <= step_ff - 1'b1;
            done_ff <= (step_ff == '0);
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/stt_timer_store.sv =====
// Timer entry storage with one write port and one read port.
module stt_timer_store
   import stt_pkg::*;
(
   input  logic             clock,
   input  entry_wr_type     wr,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_entry
);

   entry_type ents_ff [MAX_TIMERS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         if (wr.rem_only) begin
            ents_ff[wr.idx].remaining <= wr.data.remaining;
         end else begin
            ents_ff[wr.idx] <= wr.data;
         end
      end
   end

   assign rd_entry = ents_ff[rd_idx];

endmodule

// ===== tb/tb_software_timer_table.sv =====
// Self-checking testbench for the software timer table: start, stop, tick and unused items.
`timescale 1ns / 1ps

module tb_software_timer_table
   import stt_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]      status;
      logic            fired;
      logic [ID_W-1:0] consumer;
      logic            running;
      logic            last;
   } timer_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = 1'b0;
   logic [15:0] csr_wdata  = '0;

   logic [ID_W-1:0]  tbl_consumer  [MAX_TIMERS];
   logic [DIV_W-1:0] tbl_period    [MAX_TIMERS];
   logic [DIV_W-1:0] tbl_remaining [MAX_TIMERS];
   logic             tbl_periodic  [MAX_TIMERS];
   int unsigned      tbl_count    = 0;
   logic [7:0]       tbl_prescale = '0;
   logic [15:0]      cfg_resolution = 16'd1;
   logic [7:0]       cfg_ticks      = 8'd1;

   timer_result_type expected_timer_results[$];

   int unsigned send_gap_pct   = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count    = 0;
   int unsigned fault_count    = 0;
   int unsigned func_seen [4]  = '{default: 0};
   int unsigned status_seen [4] = '{default: 0};
   int unsigned result_count   = 0;
   int unsigned expiry_count   = 0;

   software_timer_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("tb_software_timer_table NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic timer_result_type blank_result(logic [1:0] status, logic fired,
                                                     logic [ID_W-1:0] who);
      timer_result_type r;
      r.status   = status;
      r.fired    = fired;
      r.consumer = who;
      r.running  = 1'b0;
      r.last     = 1'b0;
      return r;
   endfunction

   function automatic void drop_entry(int unsigned slot);
      int unsigned tail;
      tail = tbl_count - 1;
      tbl_consumer[slot]  = tbl_consumer[tail];
      tbl_period[slot]    = tbl_period[tail];
      tbl_remaining[slot] = tbl_remaining[tail];
      tbl_periodic[slot]  = tbl_periodic[tail];
      tbl_count           = tail;
   endfunction

   function automatic void predict_timer_results(logic [1:0] func, logic [ID_W-1:0] who,
                                                 logic [15:0] delay, logic per);
      timer_result_type batch[$];
      logic [15:0]   divisor;
      logic [15:0]   quotient;
      logic [8:0]    next_count;
      logic [8:0]    tick_limit;
      int unsigned   slot;
      logic          found;
      batch = {};
      found = 1'b0;
      case (func)
         FUNC_START: begin
            divisor  = (cfg_resolution == 16'd0) ? 16'd1 : cfg_resolution;
            quotient = delay / divisor;
            if (quotient == 16'd0) begin
               batch.push_back(blank_result(STATUS_BELOW_RES, 1'b0, '0));
            end else if (tbl_count >= MAX_TIMERS) begin
               batch.push_back(blank_result(STATUS_FULL, 1'b0, '0));
            end else begin
               tbl_consumer[tbl_count]  = who;
               tbl_period[tbl_count]    = quotient;
               tbl_remaining[tbl_count] = quotient;
               tbl_periodic[tbl_count]  = per;
               tbl_count++;
               batch.push_back(blank_result(STATUS_OK, 1'b0, '0));
            end
         end
         FUNC_STOP: begin
            for (slot = 0; slot < tbl_count && !found; slot++) begin
               if (tbl_consumer[slot] == who) begin
                  drop_entry(slot);
                  found = 1'b1;
               end
            end
            batch.push_back(blank_result(found ? STATUS_OK : STATUS_NOT_FOUND, 1'b0, '0));
         end
         FUNC_TICK: begin
            next_count = {1'b0, tbl_prescale} + 9'd1;
            tick_limit = (cfg_ticks == 8'd0) ? 9'd1 : {1'b0, cfg_ticks};
            if (next_count >= tick_limit) begin
               tbl_prescale = '0;
               slot = 0;
               while (slot < tbl_count) begin
                  if (tbl_remaining[slot] != '0) tbl_remaining[slot]--;
                  if (tbl_remaining[slot] == '0) begin
                     if (batch.size() < MAX_TIMERS) begin
                        batch.push_back(blank_result(STATUS_OK, 1'b1, tbl_consumer[slot]));
                     end
                     if (tbl_periodic[slot]) begin
                        tbl_remaining[slot] = tbl_period[slot];
                        slot++;
                     end else begin
                        drop_entry(slot);
                     end
                  end else begin
                     slot++;
                  end
               end
            end else begin
               tbl_prescale = next_count[7:0];
            end
            if (batch.size() == 0) batch.push_back(blank_result(STATUS_OK, 1'b0, '0));
         end
         default: begin
            batch.push_back(blank_result(STATUS_OK, 1'b0, '0));
         end
      endcase
      foreach (batch[k]) begin
         batch[k].running = (tbl_count != 0);
         batch[k].last    = (k == batch.size() - 1);
         expected_timer_results.push_back(batch[k]);
      end
   endfunction

   function automatic void report_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("MISMATCH: %s", msg);
   endfunction

   always @(posedge clock) begin
      timer_result_type got;
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = rsp_tdata[1:0];
         got.consumer = rsp_tdata[9:2];
         got.running  = rsp_tdata[10];
         got.fired    = rsp_tuser;
         got.last     = rsp_tlast;
         result_count++;
         if (expected_timer_results.size() == 0) begin
            report_fault($sformatf("unexpected item status=%0d fired=%0d id=%0d run=%0d last=%0d",
                                   got.status, got.fired, got.consumer, got.running,
                                   got.last));
         end else begin
            want = expected_timer_results.pop_front();
            status_seen[want.status]++;
            if (want.fired) expiry_count++;
            if (got !== want) begin
               report_fault($sformatf({"expected status=%0d fired=%0d id=%0d run=%0d last=%0d,",
                                       " got status=%0d fired=%0d id=%0d run=%0d last=%0d"},
                                      want.status, want.fired, want.consumer, want.running,
                                      want.last, got.status, got.fired, got.consumer,
                                      got.running, got.last));
            end
         end
      end
   end

   task automatic send_item(input logic [1:0] func, input logic [ID_W-1:0] who,
                            input logic [15:0] delay, input logic per);
      int unsigned gap;
      gap = 0;
      if (send_gap_pct != 0) begin
         while ($urandom_range(99) < send_gap_pct) gap++;
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, per, delay, who};
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      func_seen[func]++;
      predict_timer_results(func, who, delay, per);
   endtask

   task automatic wait_for_idle_block();
      req_tvalid <= 1'b0;
      while (expected_timer_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_register(input logic addr, input logic [15:0] value);
      wait_for_idle_block();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CFG_RESOLUTION) cfg_resolution = value;
      else cfg_ticks = value[7:0];
   endtask

   task automatic test_empty_table();
      send_item(FUNC_START, 8'h00, 16'd0, 1'b0);
      send_item(FUNC_STOP, 8'hFF, 16'd0, 1'b0);
      send_item(FUNC_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
      send_item(FUNC_TICK, 8'h00, 16'd0, 1'b0);
   endtask

   task automatic test_fill_and_expire();
      send_item(FUNC_START, 8'hFF, 16'hFFFF, 1'b1);
      send_item(FUNC_START, 8'd10, 16'd1, 1'b0);
      send_item(FUNC_START, 8'd10, 16'd2, 1'b1);
      send_item(FUNC_START, 8'd11, 16'd1, 1'b0);
      send_item(FUNC_START, 8'd12, 16'd1, 1'b0);
      send_item(FUNC_START, 8'd13, 16'd3, 1'b1);
      send_item(FUNC_START, 8'd14, 16'd2, 1'b0);
      send_item(FUNC_START, 8'd15, 16'd1, 1'b1);
      send_item(FUNC_START, 8'd16, 16'd5, 1'b0);
      send_item(FUNC_STOP, 8'd10, 16'd0, 1'b0);
      repeat (3) send_item(FUNC_TICK, 8'd0, 16'd0, 1'b0);
      send_item(FUNC_STOP, 8'hFF, 16'd0, 1'b0);
   endtask

   task automatic test_register_extremes();
      write_register(CFG_RESOLUTION, 16'hFFFF);
      send_item(FUNC_START, 8'd20, 16'hFFFE, 1'b1);
      send_item(FUNC_START, 8'd21, 16'hFFFF, 1'b0);
      write_register(CFG_RESOLUTION, 16'd0);
      send_item(FUNC_START, 8'd22, 16'd3, 1'b0);
      write_register(CFG_TICKS, 16'd255);
      repeat (2) send_item(FUNC_TICK, 8'd0, 16'd0, 1'b0);
      write_register(CFG_TICKS, 16'd0);
      send_item(FUNC_TICK, 8'd0, 16'd0, 1'b0);
   endtask

   task automatic run_random_traffic(input int unsigned items, input int unsigned send_pct,
                                     input int unsigned recv_pct, input logic [15:0] res,
                                     input logic [7:0] ticks);
      int unsigned pick;
      int unsigned eff;
      int unsigned span;
      logic [1:0]  func;
      logic [7:0]  who;
      logic [15:0] delay;
      logic        per;
      write_register(CFG_RESOLUTION, res);
      write_register(CFG_TICKS, {8'd0, ticks});
      send_gap_pct   = send_pct;
      recv_stall_pct = recv_pct;
      for (int unsigned n = 0; n < items; n++) begin
         if (n == items / 2) wait_for_idle_block();
         pick  = $urandom_range(99);
         who   = 8'($urandom);
         delay = 16'($urandom);
         per   = 1'($urandom);
         if (pick < 35) begin
            func = FUNC_START;
            eff  = (cfg_resolution == 16'd0) ? 1 : cfg_resolution;
            span = eff * $urandom_range(1, 6) + $urandom_range(eff - 1);
            if ($urandom_range(9) == 0) delay = 16'($urandom_range(eff - 1));
            else if ($urandom_range(9) != 0) delay = (span > 65535) ? 16'hFFFF : span[15:0];
         end else if (pick < 55) begin
            func = FUNC_STOP;
            if (tbl_count != 0 && $urandom_range(3) != 0) begin
               who = tbl_consumer[$urandom_range(tbl_count - 1)];
            end
         end else if (pick < 95) begin
            func = FUNC_TICK;
         end else begin
            func = FUNC_UNUSED;
         end
         send_item(func, who, delay, per);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      recv_stall_pct = 30;
      test_empty_table();
      test_fill_and_expire();
      test_register_extremes();
      run_random_traffic(26, 24, 55, 16'd1, 8'd1);
      run_random_traffic(26, 55, 24, 16'd3, 8'd2);
      run_random_traffic(26, 0, 0, 16'd10, 8'd1);
      wait_for_idle_block();
      repeat (40) @(posedge clock);
      $display("Sent %0d start, %0d stop, %0d tick and %0d unused items; checked %0d results.",
               func_seen[FUNC_START], func_seen[FUNC_STOP], func_seen[FUNC_TICK],
               func_seen[FUNC_UNUSED], result_count);
      $display("Saw %0d expiries, %0d below resolution, %0d table full, %0d not found.",
               expiry_count, status_seen[STATUS_BELOW_RES], status_seen[STATUS_FULL],
               status_seen[STATUS_NOT_FOUND]);
      if (fault_count == 0 && expected_timer_results.size() == 0) begin
         $display("tb_software_timer_table OK");
      end else begin
         $display("%0d mismatches, %0d results missing.", fault_count,
                  expected_timer_results.size());
         $display("tb_software_timer_table NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/stt_pkg.sv
src/stt_divider.sv
src/stt_timer_store.sv
src/software_timer_table.sv
tb/tb_software_timer_table.sv
